@@ design/tis_pkg.sv @@
// Shared types, constants and helpers for the TDC interval smoother.
// Used by the controller, the datapath, the divider and the top level.
// No dependencies.
package tis_pkg;

   localparam int FINE_W   = 23;
   localparam int COARSE_W = 16;
   localparam int OUT_W    = 48;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 2;

   localparam int PERIOD_W = 10;
   localparam int SPAN_W   = 6;
   localparam int OFFSET_W = 24;
   localparam int WEIGHT_W = 17;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(125);
   localparam logic [SPAN_W-1:0]   SPAN_RESET   = SPAN_W'(9);
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(1000000);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(13107);
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(65536);

   localparam int Q_SHIFT  = 16;
   localparam int FE_SHIFT = 12;
   localparam int FE_DEN   = 62500;
   localparam int FE_HALF  = FE_DEN / 2;

   localparam int DIV_W     = 62;
   localparam int DEN_W     = 23;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN48 = -MAX48 - 64'sd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLOCK_PERIOD = 2'd0,
      CSR_CAL_SPAN     = 2'd1,
      CSR_OFFSET       = 2'd2,
      CSR_WEIGHT       = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PROD,
      OP_DIV1_START,
      OP_INTERVAL,
      OP_TIME_ERROR,
      OP_DIV2_START,
      OP_FREQ_ERROR,
      OP_AVG_LOAD,
      OP_EMA_DIFF_T,
      OP_EMA_DIFF_F,
      OP_EMA_MUL,
      OP_EMA_SUM_T,
      OP_EMA_SUM_F,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PROD,
      S_DIV1,
      S_WAIT1,
      S_INTERVAL,
      S_TIME_ERROR,
      S_DIV2,
      S_WAIT2,
      S_FREQ_ERROR,
      S_AVG_T,
      S_MUL_T,
      S_SUM_T,
      S_DIFF_F,
      S_MUL_F,
      S_SUM_F,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic reject;
      logic started;
      logic div_busy;
      logic out_free;
   } status_type;

   function automatic logic signed [OUT_W-1:0] sat48(input logic signed [63:0] v);
      logic signed [63:0] r;
      if (v > MAX48) begin
         r = MAX48;
      end else if (v < MIN48) begin
         r = MIN48;
      end else begin
         r = v;
      end
      return r[OUT_W-1:0];
   endfunction

endpackage

@@ design/tis_divider.sv @@
// Iterative restoring divider, two quotient bits per cycle.
// Depends on tis_pkg for widths and step count.
module tis_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [tis_pkg::DIV_W-1:0] dividend,
   input  logic [tis_pkg::DEN_W-1:0] divisor,
   output logic                     busy,
   output logic [tis_pkg::DIV_W-1:0] quotient
);
   import tis_pkg::*;

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff;

   always_comb begin
      logic [DEN_W:0]   t;
      logic [DEN_W-1:0] r;
      logic [DIV_W-1:0] q;
      r = rem_ff;
      q = quo_ff;
      for (int k = 0; k < 2; k++) begin
         t = {r, q[DIV_W-1]};
         q = {q[DIV_W-2:0], 1'b0};
         if (t >= {1'b0, den_ff}) begin
            t = t - {1'b0, den_ff};
            q[0] = 1'b1;
         end
         r = t[DEN_W-1:0];
      end
      rem_in = r;
      quo_in = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ design/tis_ctrl.sv @@
// Sequencer for the TDC interval smoother: steps one item through the datapath.
// Depends on tis_pkg for the state, op and status types.
module tis_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tis_pkg::status_type status,
   output tis_pkg::op_type     op
);
   import tis_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            if (status.reject) begin
               state_in = S_EMIT;
            end else begin
               op       = OP_PROD;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            op       = OP_DIV1_START;
            state_in = S_WAIT1;
         end
         S_WAIT1: begin
            if (!status.div_busy) begin
               state_in = S_INTERVAL;
            end
         end
         S_INTERVAL: begin
            op       = OP_INTERVAL;
            state_in = S_TIME_ERROR;
         end
         S_TIME_ERROR: begin
            op       = OP_TIME_ERROR;
            state_in = S_DIV2;
         end
         S_DIV2: begin
            op       = OP_DIV2_START;
            state_in = S_WAIT2;
         end
         S_WAIT2: begin
            if (!status.div_busy) begin
               state_in = S_FREQ_ERROR;
            end
         end
         S_FREQ_ERROR: begin
            op       = OP_FREQ_ERROR;
            state_in = S_AVG_T;
         end
         S_AVG_T: begin
            if (!status.started) begin
               op       = OP_AVG_LOAD;
               state_in = S_EMIT;
            end else begin
               op       = OP_EMA_DIFF_T;
               state_in = S_MUL_T;
            end
         end
         S_MUL_T: begin
            op       = OP_EMA_MUL;
            state_in = S_SUM_T;
         end
         S_SUM_T: begin
            op       = OP_EMA_SUM_T;
            state_in = S_DIFF_F;
         end
         S_DIFF_F: begin
            op       = OP_EMA_DIFF_F;
            state_in = S_MUL_F;
         end
         S_MUL_F: begin
            op       = OP_EMA_MUL;
            state_in = S_SUM_F;
         end
         S_SUM_F: begin
            op       = OP_EMA_SUM_F;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               op       = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ design/tis_datapath.sv @@
// Datapath of the TDC interval smoother: config registers, arithmetic,
// running state and the result register. Depends on tis_pkg and tis_divider.
module tis_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tis_pkg::op_type                      op,
   output tis_pkg::status_type                  status,
   input  logic                                 csr_wr_en,
   input  logic [tis_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tis_pkg::CSR_W-1:0]            csr_wdata,
   input  logic [tis_pkg::FINE_W-1:0]           req_fine_start,
   input  logic [tis_pkg::FINE_W-1:0]           req_fine_stop,
   input  logic [tis_pkg::COARSE_W-1:0]         req_coarse_count,
   input  logic [tis_pkg::FINE_W-1:0]           req_cal_low,
   input  logic [tis_pkg::FINE_W-1:0]           req_cal_high,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_ok,
   output logic signed [tis_pkg::OUT_W-1:0]     rsp_interval_q16_ns,
   output logic signed [tis_pkg::OUT_W-1:0]     rsp_time_error_q16_ns,
   output logic signed [tis_pkg::OUT_W-1:0]     rsp_freq_error_q32_mhz,
   output logic signed [tis_pkg::OUT_W-1:0]     rsp_time_error_avg,
   output logic signed [tis_pkg::OUT_W-1:0]     rsp_freq_error_avg
);
   import tis_pkg::*;

   logic [PERIOD_W-1:0] period_ff;
   logic [SPAN_W-1:0]   span_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [WEIGHT_W-1:0] weight_clamped;

   logic signed [OUT_W-1:0] prev_ff, avg_t_ff, avg_f_ff;
   logic                    started_ff;

   logic                    reject_ff;
   logic signed [FINE_W:0]  diff_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [15:0]             ps_ff;
   logic [25:0]             cp_ff;
   logic signed [40:0]      prod_ff;
   logic                    div_neg_ff;
   logic signed [OUT_W-1:0] interval_ff, te_ff, fe_ff;
   logic                    ema_neg_ff;
   logic [OUT_W-1:0]        ema_mag_ff;
   logic [39:0]             plo_ff, phi_ff;

   logic                    rsp_valid_ff, rsp_ok_ff;
   logic signed [OUT_W-1:0] rsp_interval_ff, rsp_te_ff, rsp_fe_ff, rsp_avg_t_ff, rsp_avg_f_ff;

   logic                    div_start, div_busy;
   logic [DIV_W-1:0]        div_dividend, div_quotient;
   logic [DEN_W-1:0]        div_divisor;

   logic [40:0]             prod_mag;
   logic signed [63:0]      d2, d2_mag, q_signed, interval_sum, te_sum;
   logic signed [OUT_W-1:0] interval_val, te_val, fe_val;
   logic signed [OUT_W:0]   ema_d;
   logic [OUT_W:0]          ema_abs;
   logic signed [OUT_W-1:0] ema_x, ema_avg, ema_new;
   logic [63:0]             ema_sum;

   assign weight_clamped = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;

   always_comb begin
      prod_mag     = prod_ff[40] ? 41'(-prod_ff) : 41'(prod_ff);
      d2           = {{16{te_ff[OUT_W-1]}}, te_ff} - {{16{prev_ff[OUT_W-1]}}, prev_ff};
      d2_mag       = d2[63] ? -d2 : d2;
      div_start    = (op == OP_DIV1_START) || (op == OP_DIV2_START);
      if (op == OP_DIV2_START) begin
         div_dividend = DIV_W'({d2_mag[OUT_W:0], {FE_SHIFT{1'b0}}}) + DIV_W'(FE_HALF);
         div_divisor  = DEN_W'(FE_DEN);
      end else begin
         div_dividend = DIV_W'({prod_mag, {Q_SHIFT{1'b0}}}) + DIV_W'(den_ff >> 1);
         div_divisor  = den_ff;
      end

      q_signed     = div_neg_ff ? -$signed({2'b00, div_quotient})
                                :  $signed({2'b00, div_quotient});
      interval_sum = q_signed + $signed({22'b0, cp_ff, {Q_SHIFT{1'b0}}});
      interval_val = sat48(interval_sum);
      te_sum       = {{16{interval_ff[OUT_W-1]}}, interval_ff}
                     - $signed({24'b0, offset_ff, {Q_SHIFT{1'b0}}});
      te_val       = sat48(te_sum);
      fe_val       = sat48(q_signed);

      if (op == OP_EMA_DIFF_F || op == OP_EMA_SUM_F) begin
         ema_x   = fe_ff;
         ema_avg = avg_f_ff;
      end else begin
         ema_x   = te_ff;
         ema_avg = avg_t_ff;
      end
      ema_d   = {ema_x[OUT_W-1], ema_x} - {ema_avg[OUT_W-1], ema_avg};
      ema_abs = ema_d[OUT_W] ? OUT_W'(1)'(0) + (OUT_W+1)'(-ema_d) : (OUT_W+1)'(ema_d);
      ema_sum = {24'b0, plo_ff} + {phi_ff, 24'b0} + 64'd32768;
      ema_new = ema_neg_ff ? ema_avg - $signed(ema_sum[63:Q_SHIFT])
                           : ema_avg + $signed(ema_sum[63:Q_SHIFT]);
   end

   tis_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         span_ff    <= SPAN_RESET;
         offset_ff  <= OFFSET_RESET;
         weight_ff  <= WEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_CLOCK_PERIOD: period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_CAL_SPAN:     span_ff   <= csr_wdata[SPAN_W-1:0];
            CSR_OFFSET:       offset_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_WEIGHT:       weight_ff <= csr_wdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         avg_t_ff   <= '0;
         avg_f_ff   <= '0;
         started_ff <= 1'b0;
      end else begin
         case (op)
            OP_FREQ_ERROR: prev_ff <= te_ff;
            OP_AVG_LOAD: begin
               avg_t_ff   <= te_ff;
               avg_f_ff   <= fe_ff;
               started_ff <= 1'b1;
            end
            OP_EMA_SUM_T:  avg_t_ff <= ema_new;
            OP_EMA_SUM_F:  avg_f_ff <= ema_new;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reject_ff <= 1'b0;
      end else if (op == OP_LOAD) begin
         reject_ff <= (req_cal_high <= req_cal_low) || (req_coarse_count == '0);
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         OP_LOAD: begin
            diff_ff <= $signed({1'b0, req_fine_start}) - $signed({1'b0, req_fine_stop});
            den_ff  <= req_cal_high - req_cal_low;
            ps_ff   <= 16'(period_ff * span_ff);
            cp_ff   <= 26'(req_coarse_count * period_ff);
         end
         OP_PROD:       prod_ff <= 41'($signed({1'b0, ps_ff}) * diff_ff);
         OP_DIV1_START: div_neg_ff <= prod_ff[40];
         OP_INTERVAL:   interval_ff <= interval_val;
         OP_TIME_ERROR: te_ff <= te_val;
         OP_DIV2_START: div_neg_ff <= d2[63];
         OP_FREQ_ERROR: fe_ff <= fe_val;
         OP_EMA_DIFF_T, OP_EMA_DIFF_F: begin
            ema_neg_ff <= ema_d[OUT_W];
            ema_mag_ff <= ema_abs[OUT_W-1:0];
         end
         OP_EMA_MUL: begin
            plo_ff <= 40'(ema_mag_ff[23:0] * weight_clamped);
            phi_ff <= 40'(ema_mag_ff[OUT_W-1:24] * weight_clamped);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (op == OP_EMIT) begin
         rsp_ok_ff <= !reject_ff;
         if (reject_ff) begin
            rsp_interval_ff <= '0;
            rsp_te_ff       <= '0;
            rsp_fe_ff       <= '0;
            rsp_avg_t_ff    <= '0;
            rsp_avg_f_ff    <= '0;
         end else begin
            rsp_interval_ff <= interval_ff;
            rsp_te_ff       <= te_ff;
            rsp_fe_ff       <= fe_ff;
            rsp_avg_t_ff    <= avg_t_ff;
            rsp_avg_f_ff    <= avg_f_ff;
         end
      end
   end

   assign status.reject   = reject_ff;
   assign status.started  = started_ff;
   assign status.div_busy = div_busy;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_ok                 = rsp_ok_ff;
   assign rsp_interval_q16_ns    = rsp_interval_ff;
   assign rsp_time_error_q16_ns  = rsp_te_ff;
   assign rsp_freq_error_q32_mhz = rsp_fe_ff;
   assign rsp_time_error_avg     = rsp_avg_t_ff;
   assign rsp_freq_error_avg     = rsp_avg_f_ff;

endmodule

@@ design/tdc_interval_smoother.sv @@
// TDC interval smoother, top level: one converter reading in, one result out.
// Depends on tis_pkg, tis_ctrl and tis_datapath.
//
// Each item is one converter reading. The block forms the interval in Q.16 ns,
// the time error against the programmed offset, the frequency error in Q.32 mHz
// from the change of the time error, and exponential averages of both (the first
// valid reading loads them). A valid reading makes two passes through the shared
// divider, which retires two quotient bits per cycle over a 62-bit dividend. A
// rejected reading (cal_high not above cal_low, or a zero coarse count) skips the
// arithmetic and returns ok low with all fields zero. A new reading is accepted
// only once the current one has been emitted. The result sits in an output
// register, so the next reading is taken while it waits to be collected.
// Program the registers through the csr port only while no item is in flight.
module tdc_interval_smoother (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [tis_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tis_pkg::CSR_W-1:0]        csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tis_pkg::FINE_W-1:0]       req_fine_start,
   input  logic [tis_pkg::FINE_W-1:0]       req_fine_stop,
   input  logic [tis_pkg::COARSE_W-1:0]     req_coarse_count,
   input  logic [tis_pkg::FINE_W-1:0]       req_cal_low,
   input  logic [tis_pkg::FINE_W-1:0]       req_cal_high,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_ok,
   output logic signed [tis_pkg::OUT_W-1:0] rsp_interval_q16_ns,
   output logic signed [tis_pkg::OUT_W-1:0] rsp_time_error_q16_ns,
   output logic signed [tis_pkg::OUT_W-1:0] rsp_freq_error_q32_mhz,
   output logic signed [tis_pkg::OUT_W-1:0] rsp_time_error_avg,
   output logic signed [tis_pkg::OUT_W-1:0] rsp_freq_error_avg
);
   import tis_pkg::*;

   op_type     op;
   status_type status;

   tis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .op        (op)
   );

   tis_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .op                     (op),
      .status                 (status),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_fine_start         (req_fine_start),
      .req_fine_stop          (req_fine_stop),
      .req_coarse_count       (req_coarse_count),
      .req_cal_low            (req_cal_low),
      .req_cal_high           (req_cal_high),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_ok                 (rsp_ok),
      .rsp_interval_q16_ns    (rsp_interval_q16_ns),
      .rsp_time_error_q16_ns  (rsp_time_error_q16_ns),
      .rsp_freq_error_q32_mhz (rsp_freq_error_q32_mhz),
      .rsp_time_error_avg     (rsp_time_error_avg),
      .rsp_freq_error_avg     (rsp_freq_error_avg)
   );

endmodule
